### rtl/core/bcfl_pkg.sv
// Package for the block-carving free-list slot allocator.
// Shared constants, payload structs, codes and controller/datapath interface types.
// No dependencies.
`default_nettype none

package bcfl_pkg;

    localparam int SLOTS_PER_BLOCK = 512;
    localparam int MAX_BLOCKS      = 8;

    localparam int SLOT_W     = 12;
    localparam int SLOT_SPACE = 1 << SLOT_W;
    // Width that holds a slot number or a block end, up to SLOT_SPACE itself
    localparam int END_W      = SLOT_W + 1;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [END_W-1:0]  SPB_END   = END_W'(SLOTS_PER_BLOCK);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOT_SPACE);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NULL_FREE = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic                has_slot;
        logic [SLOT_W-1:0]   slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        status_t             status;
    } rsp_t;

    // One link-memory word: written flag, carve end at write time, link
    typedef struct packed {
        logic                written;
        logic [END_W-1:0]    end_mark;
        logic [LINK_W-1:0]   link;
    } link_entry_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_POP   = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic clear_step;
        logic exec;
        logic pop_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_pop;
        logic rsp_busy;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/bcfl_ctrl.sv
// Controller for the slot allocator: clear sweep after reset, accept, list pop.
// Depends on bcfl_pkg.
`default_nettype none

module bcfl_ctrl
    import bcfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire dp_status_t  status,
    output ctrl_cmd_t        cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid && !status.rsp_busy && status.need_pop)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.exec       = 1'b0;
        cmd.pop_finish = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = !status.rsp_busy;
                cmd.exec  = req_valid && !status.rsp_busy;
            end
            S_POP:
            begin
                cmd.pop_finish = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (state_reg == S_IDLE))
        else $error("pop did not return to idle");
`endif

endmodule

`default_nettype wire

### rtl/core/bcfl_dp.sv
// Datapath for the slot allocator: link memory, list head, carve counters, response register.
// Depends on bcfl_pkg; driven by bcfl_ctrl commands.
`default_nettype none

module bcfl_dp
    import bcfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire req_t        req,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       status,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp
);

    link_entry_t link_mem [SLOT_SPACE];
    link_entry_t rd_data_reg;

    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] clr_cnt_next;
    logic [SLOT_W-1:0] list_head_reg;
    logic [SLOT_W-1:0] list_head_next;
    logic              head_valid_reg;
    logic              head_valid_next;
    logic [CNT_W-1:0]  blocks_carved_reg;
    logic [CNT_W-1:0]  blocks_carved_next;
    logic [END_W-1:0]  carve_end_reg;
    logic [END_W-1:0]  carve_end_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    link_entry_t       mem_wdata;

    logic              exhausted;
    logic [END_W-1:0]  head_ext;
    logic [END_W-1:0]  head_inc;
    logic              link_ok;
    logic [LINK_W-1:0] implied_link;
    logic [LINK_W-1:0] next_link;

    // A stored link counts only if written after its block's carve, or its
    // block is not carved yet.
    assign head_ext     = {1'b0, list_head_reg};
    assign head_inc     = head_ext + END_W'(1);
    assign link_ok      = rd_data_reg.written &&
                          ((head_ext < rd_data_reg.end_mark) || (head_ext >= carve_end_reg));
    // Implied links only occur inside the most recently carved block
    assign implied_link = (head_inc == carve_end_reg) ? LINK_NONE : head_inc;
    assign next_link    = link_ok ? rd_data_reg.link : implied_link;

    assign exhausted = (blocks_carved_reg >= CNT_W'(MAX_BLOCKS)) ||
                       (({1'b0, carve_end_reg} + {1'b0, SPB_END}) >
                        (END_W + 1)'(SLOT_SPACE));

    assign status.clear_last = cmd.clear_step && (clr_cnt_reg == '1);
    assign status.need_pop   = (req.opcode == OP_ALLOC) && head_valid_reg;
    assign status.rsp_busy   = rsp_valid_reg && !rsp_ready;

    always_comb
    begin
        clr_cnt_next       = clr_cnt_reg;
        list_head_next     = list_head_reg;
        head_valid_next    = head_valid_reg;
        blocks_carved_next = blocks_carved_reg;
        carve_end_next     = carve_end_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;
        rsp_next           = rsp_reg;
        mem_we             = 1'b0;
        mem_waddr          = clr_cnt_reg;
        mem_wdata          = '0;

        if (cmd.clear_step)
        begin
            mem_we       = 1'b1;
            clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
        end

        if (cmd.exec)
        begin
            case (req.opcode)
                OP_FREE:
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.granted_slot = '0;
                    if (req.has_slot)
                    begin
                        rsp_next.status    = ST_DONE;
                        mem_we             = 1'b1;
                        mem_waddr          = req.slot_index;
                        mem_wdata.written  = 1'b1;
                        mem_wdata.end_mark = carve_end_reg;
                        mem_wdata.link     = head_valid_reg ? {1'b0, list_head_reg} : LINK_NONE;
                        list_head_next     = req.slot_index;
                        head_valid_next    = 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = ST_NULL_FREE;
                    end
                end
                OP_ALLOC:
                begin
                    // A non-empty list reads the head's link and finishes next cycle
                    if (!head_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        if (exhausted)
                        begin
                            rsp_next.granted_slot = '0;
                            rsp_next.status       = ST_EXHAUSTED;
                        end
                        else
                        begin
                            rsp_next.granted_slot = carve_end_reg[SLOT_W-1:0];
                            rsp_next.status       = ST_DONE;
                            list_head_next        = carve_end_reg[SLOT_W-1:0] + SLOT_W'(1);
                            head_valid_next       = 1'b1;
                            blocks_carved_next    = blocks_carved_reg + CNT_W'(1);
                            carve_end_next        = carve_end_reg + SPB_END;
                        end
                    end
                end
                default:
                begin
                    rsp_next = rsp_reg;
                end
            endcase
        end

        if (cmd.pop_finish)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.granted_slot = list_head_reg;
            rsp_next.status       = ST_DONE;
            if (next_link[SLOT_W])
            begin
                head_valid_next = 1'b0;
                list_head_next  = '0;
            end
            else
            begin
                list_head_next = next_link[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= link_mem[list_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg       <= '0;
            list_head_reg     <= '0;
            head_valid_reg    <= 1'b0;
            blocks_carved_reg <= '0;
            carve_end_reg     <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            clr_cnt_reg       <= clr_cnt_next;
            list_head_reg     <= list_head_next;
            head_valid_reg    <= head_valid_next;
            blocks_carved_reg <= blocks_carved_next;
            carve_end_reg     <= carve_end_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid_reg |-> (list_head_reg == '0))
        else $error("empty list with nonzero head");

    a_carve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blocks_carved_reg <= CNT_W'(MAX_BLOCKS))
        else $error("carved more blocks than allowed");

    a_carve_end_track: assert property (@(posedge clk) disable iff (!rst_n)
        ((END_W + CNT_W)'(blocks_carved_reg) * (END_W + CNT_W)'(SLOTS_PER_BLOCK)) ==
        (END_W + CNT_W)'(carve_end_reg))
        else $error("carve end out of step with block count");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_finish |-> (!rsp_valid_reg && $past(head_valid_reg)))
        else $error("pop finished without free response slot or list head");
`endif

endmodule

`default_nettype wire

### rtl/core/block_carving_free_list_allocator_top.sv
// Top level of the block-carving free-list slot allocator.
// Depends on bcfl_pkg, bcfl_ctrl and bcfl_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   req     | req_valid / req_ready  | opcode, has_slot, slot_index
//   rsp     | rsp_valid / rsp_ready  | granted_slot, status
//
// Free, null free, carve and exhausted allocate: the response register is loaded at transfer.
// Allocate from a non-empty list: the head's link is read into a register, then the pop state loads the response.
// After reset a pass over all 4096 link-memory entries clears them; req_ready stays low until it ends.
// A request is taken only while the response register is empty or draining in that cycle.
`default_nettype none

module block_carving_free_list_allocator_top
    import bcfl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcfl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
